FILE: rtl/mor_pkg.sv
// ----------------------------------------------------------------------------
// mor_pkg: shared definitions for the largest rectangle of ones block
// Sizes, the bar stack entry type, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mor_pkg;

    // Matrix limits.
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    // Derived widths.
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int HGT_W  = $clog2(MAX_ROWS + 1);
    localparam int AREA_W = 13;
    localparam int PROD_W = HGT_W + CNT_W;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int RL_W   = 7;
    localparam logic        REG_ROW_LENGTH = 1'b0;
    localparam logic [RL_W-1:0] ROW_LENGTH_RESET = RL_W'(64);

    // Saturation limits.
    localparam logic [HGT_W-1:0]  HGT_SAT  = HGT_W'(MAX_ROWS);
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // One stacked bar: the column where it starts and its height.
    typedef struct packed {
        logic [COL_W-1:0] start;
        logic [HGT_W-1:0] height;
    } bar_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_HGT,
        S_POP_RD,
        S_POP_CMP,
        S_PUSH,
        S_FL_RD,
        S_FL_CMP,
        S_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic upd_hgt;
        logic stk_rd;
        logic pop;
        logic push;
        logic flush_start;
        logic advance;
        logic row_done;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stk_empty;
        logic top_ge;
        logic row_end;
        logic last;
        logic pipe_idle;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/mor_if.sv
// ----------------------------------------------------------------------------
// mor_if: valid/ready channels of the largest rectangle of ones block
// The cell channel carries one matrix cell per transaction, the area channel
// carries one result per matrix.
// ----------------------------------------------------------------------------
interface mor_cell_if;
    logic valid;
    logic ready;
    logic cell_req;
    logic last_cell;

    modport source (output valid, output cell_req, output last_cell, input ready);
    modport sink   (input valid, input cell_req, input last_cell, output ready);
endinterface

interface mor_area_if;
    import mor_pkg::*;

    logic              valid;
    logic              ready;
    logic [AREA_W-1:0] max_area;

    modport source (output valid, output max_area, input ready);
    modport sink   (input valid, input max_area, output ready);
endinterface

FILE: rtl/mor_ctrl.sv
// ----------------------------------------------------------------------------
// mor_ctrl: sequencer of the largest rectangle of ones block
// Steps one cell through height update, stack pops and push, and flushes the
// stack at each row end. Drives the datapath by commands only.
// ----------------------------------------------------------------------------
module mor_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mor_pkg::status_t status,
    output mor_pkg::cmd_t    cmd
);
    import mor_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HGT;
                end
            end
            S_HGT:
            begin
                state_next = S_POP_RD;
            end
            S_POP_RD:
            begin
                state_next = status.stk_empty ? S_PUSH : S_POP_CMP;
            end
            S_POP_CMP:
            begin
                state_next = status.top_ge ? S_POP_RD : S_PUSH;
            end
            S_PUSH:
            begin
                state_next = status.row_end ? S_FL_RD : S_IDLE;
            end
            S_FL_RD:
            begin
                if (!status.stk_empty)
                begin
                    state_next = S_FL_CMP;
                end
                else if (status.last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FL_CMP:
            begin
                state_next = S_FL_RD;
            end
            S_DRAIN:
            begin
                if (status.pipe_idle && status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_HGT:
            begin
                cmd.upd_hgt = 1'b1;
            end
            S_POP_RD:
            begin
                cmd.stk_rd = !status.stk_empty;
            end
            S_POP_CMP:
            begin
                cmd.pop = status.top_ge;
            end
            S_PUSH:
            begin
                cmd.push        = 1'b1;
                cmd.flush_start = status.row_end;
                cmd.advance     = !status.row_end;
            end
            S_FL_RD:
            begin
                cmd.stk_rd   = !status.stk_empty;
                cmd.row_done = status.stk_empty;
            end
            S_FL_CMP:
            begin
                cmd.pop = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.finish = status.pipe_idle && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/mor_dpath.sv
// ----------------------------------------------------------------------------
// mor_dpath: datapath of the largest rectangle of ones block
// Holds the column height memory, the bar stack memory, the area pipeline
// and the best area, and the output register of the result channel.
// ----------------------------------------------------------------------------
module mor_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mor_pkg::cmd_t               cmd,
    output mor_pkg::status_t            status,
    input  logic [mor_pkg::RL_W-1:0]    row_length,
    input  logic                        cell_req,
    input  logic                        last_cell,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mor_pkg::AREA_W-1:0]  max_area
);
    import mor_pkg::*;

    // Memories.
    logic [HGT_W-1:0] hgt_mem [MAX_COLS];
    bar_t             stk_mem [MAX_COLS];

    logic [MAX_COLS-1:0] hvalid_reg;
    logic [HGT_W-1:0]    hgt_rd_reg;
    bar_t                stk_rd_reg;

    logic                cell_reg;
    logic                last_reg;
    logic [COL_W-1:0]    col_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [HGT_W-1:0]    h_reg;
    logic [COL_W-1:0]    start_reg;
    logic [CNT_W-1:0]    end_reg;

    logic                op_valid_reg;
    logic [HGT_W-1:0]    op_h_reg;
    logic [CNT_W-1:0]    op_w_reg;
    logic                prod_valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [AREA_W-1:0]   best_reg;
    logic                out_valid_reg;
    logic [AREA_W-1:0]   out_area_reg;

    logic [HGT_W-1:0]    hgt_cur;
    logic [HGT_W-1:0]    h_next;
    logic [CNT_W-1:0]    col_inc;
    logic [CNT_W-1:0]    len_eff;
    logic [CNT_W-1:0]    top_idx;
    logic [AREA_W-1:0]   area_sat;

    // Effective row length: zero acts as one, long rows are clipped.
    always_comb
    begin
        if (row_length == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (CNT_W'(row_length) > CNT_W'(MAX_COLS))
        begin
            len_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            len_eff = CNT_W'(row_length);
        end
    end

    assign col_inc = {1'b0, col_reg} + CNT_W'(1);
    assign top_idx = count_reg - CNT_W'(1);

    // New height of the current column, saturating at the row limit.
    always_comb
    begin
        hgt_cur = hvalid_reg[col_reg] ? hgt_rd_reg : '0;
        if (!cell_reg)
        begin
            h_next = '0;
        end
        else if (hgt_cur >= HGT_SAT)
        begin
            h_next = HGT_SAT;
        end
        else
        begin
            h_next = hgt_cur + HGT_W'(1);
        end
    end

    // Column height memory, with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hgt_rd_reg <= hgt_mem[col_reg];
        end
        if (cmd.upd_hgt)
        begin
            hgt_mem[col_reg] <= h_next;
        end
    end

    // Bar stack memory, with registered read of the top entry.
    always_ff @(posedge clk)
    begin
        if (cmd.stk_rd)
        begin
            stk_rd_reg <= stk_mem[top_idx[COL_W-1:0]];
        end
        if (cmd.push && (count_reg != CNT_W'(MAX_COLS)))
        begin
            stk_mem[count_reg[COL_W-1:0]] <= '{start: start_reg, height: h_reg};
        end
    end

    // Per-item payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cell_reg <= cell_req;
            last_reg <= last_cell;
        end
        if (cmd.upd_hgt)
        begin
            h_reg     <= h_next;
            start_reg <= col_reg;
            end_reg   <= {1'b0, col_reg};
        end
        else if (cmd.pop)
        begin
            start_reg <= stk_rd_reg.start;
        end
        if (cmd.flush_start)
        begin
            end_reg <= col_inc;
        end
        if (cmd.pop)
        begin
            op_h_reg <= stk_rd_reg.height;
            op_w_reg <= end_reg - {1'b0, stk_rd_reg.start};
        end
        prod_reg <= PROD_W'(op_h_reg) * PROD_W'(op_w_reg);
        if (cmd.finish)
        begin
            out_area_reg <= best_reg;
        end
    end

    // Height valid bits: set on write, all cleared when a matrix ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
        end
        else if (cmd.finish)
        begin
            hvalid_reg <= '0;
        end
        else if (cmd.upd_hgt)
        begin
            hvalid_reg[col_reg] <= 1'b1;
        end
    end

    // Column position and stack depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.advance)
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
            else if (cmd.row_done || cmd.finish)
            begin
                col_reg <= '0;
            end

            if (cmd.row_done || cmd.finish)
            begin
                count_reg <= '0;
            end
            else if (cmd.pop)
            begin
                count_reg <= top_idx;
            end
            else if (cmd.push && (count_reg != CNT_W'(MAX_COLS)))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Saturated area of the product stage.
    assign area_sat = (prod_reg > PROD_W'(AREA_MAX)) ? AREA_MAX : prod_reg[AREA_W-1:0];

    // Area pipeline: operands, product, then best-area compare.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            op_valid_reg   <= cmd.pop && (end_reg > {1'b0, stk_rd_reg.start});
            prod_valid_reg <= op_valid_reg;
            if (cmd.finish)
            begin
                best_reg <= '0;
            end
            else if (prod_valid_reg && (area_sat > best_reg))
            begin
                best_reg <= area_sat;
            end
        end
    end

    // Result output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_area  = out_area_reg;

    // Status toward the controller.
    always_comb
    begin
        status.stk_empty = (count_reg == '0);
        status.top_ge    = (stk_rd_reg.height >= h_reg);
        status.row_end   = last_reg || (col_inc >= len_eff);
        status.last      = last_reg;
        status.pipe_idle = !op_valid_reg && !prod_valid_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // A pop never runs on an empty stack.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop issued on an empty bar stack");

    // A push always finds room, since a row has at most MAX_COLS columns.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < CNT_W'(MAX_COLS)))
        else $error("push issued on a full bar stack");

    // The result is taken only after all pending areas reached the best.
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!op_valid_reg && !prod_valid_reg))
        else $error("result loaded while areas still pending");

    // A result appears only from a finish command.
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result valid without a finish command");

endmodule

FILE: rtl/max_ones_rectangle.sv
// ----------------------------------------------------------------------------
// max_ones_rectangle: area of the largest all-ones rectangle in a matrix
// Top level with the configuration register, the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// Cells arrive on cell_in in row-major order, one per transaction, with
// last_cell set on the final cell of the matrix. row_length (APB, byte
// address 0) sets the number of columns per row; zero acts as one and values
// above 64 act as 64. The user must write it only while the block is idle;
// the block itself does not enforce this. For each matrix one transaction on
// area_out carries max_area, the area of the largest rectangle of ones seen.
// A cell is accepted and its height updated; each bar it pops from the
// monotonic stack takes a read and a compare step, then the cell is pushed;
// at a row end the flush reads and pops each remaining bar. Every column is
// pushed and popped once per row; a new cell waits until the previous one is
// done. The bar stack memory's registered read port splits each pop into read
// and compare. After the final row's flush, the result is loaded once pending
// areas have drained and the output register is free.
// The output register holds the result while the receiver stalls; cells keep
// being accepted, and only a further matrix end waits for the register.
// Reset clears heights, stack, column position and best area at once and sets
// row_length to 64.
// ----------------------------------------------------------------------------
module max_ones_rectangle (
    input  logic                          clk,
    input  logic                          rst_n,
    mor_cell_if.sink                      cell_in,
    mor_area_if.source                    area_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mor_pkg::ADDR_W-1:0]    paddr,
    input  logic [mor_pkg::DATA_W-1:0]    pwdata,
    output logic [mor_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import mor_pkg::*;

    logic [RL_W-1:0] row_length_reg;
    logic            reg_hit;
    cmd_t            cmd;
    status_t         status;

    // Register decode: one word register at byte address 0.
    assign reg_hit = (paddr[2] == REG_ROW_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DATA_W'(row_length_reg) : '0;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            row_length_reg <= pwdata[RL_W-1:0];
        end
    end

    // Sequencer.
    mor_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_in.valid),
        .in_ready (cell_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    mor_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .row_length (row_length_reg),
        .cell_req   (cell_in.cell_req),
        .last_cell  (cell_in.last_cell),
        .out_valid  (area_out.valid),
        .out_ready  (area_out.ready),
        .max_area   (area_out.max_area)
    );

endmodule
